// ----- rtl/core/psdc_pkg.sv -----
// Shared types, constants and symbol decode functions for the pairwise
// site distance counter. No dependencies.
package psdc_pkg;

	localparam int SUM_W    = 36;
	localparam int SYM_W    = 8;
	localparam int WEIGHT_W = 16;
	localparam int LIMIT_W  = 7;
	localparam int INDEX_W  = 2;

	localparam logic [1:0] KIND_NUC   = 2'd0;
	localparam logic [1:0] KIND_AMINO = 2'd1;

	localparam logic [INDEX_W-1:0] CFG_KIND  = 2'd0;
	localparam logic [INDEX_W-1:0] CFG_CODED = 2'd1;
	localparam logic [INDEX_W-1:0] CFG_LIMIT = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd20;

	localparam logic [1:0] NUC_A = 2'd0;
	localparam logic [1:0] NUC_C = 2'd1;
	localparam logic [1:0] NUC_G = 2'd2;
	localparam logic [1:0] NUC_T = 2'd3;
	localparam logic [1:0] TRANSITION_XOR = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic               coded;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic             ok;
		logic [1:0]       code;
	} nuc_t;

	typedef struct packed {
		logic [SUM_W-1:0] mismatch;
		logic [SUM_W-1:0] transition;
		logic [SUM_W-1:0] transversion;
		logic [SUM_W-1:0] valid;
		logic [SUM_W-1:0] den;
	} pair_sums_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} bk_state_t;

	function automatic nuc_t nuc_decode(input logic [SYM_W-1:0] sym, input logic coded);
		nuc_t r;
		r.ok   = 1'b0;
		r.code = NUC_A;
		if (coded) begin
			r.ok   = (sym < 8'd4);
			r.code = sym[1:0];
		end else begin
			case (sym)
				"A", "a": begin
					r.ok = 1'b1; r.code = NUC_A;
				end
				"C", "c": begin
					r.ok = 1'b1; r.code = NUC_C;
				end
				"G", "g": begin
					r.ok = 1'b1; r.code = NUC_G;
				end
				"T", "t", "U", "u": begin
					r.ok = 1'b1; r.code = NUC_T;
				end
				default: begin
					r.ok = 1'b0; r.code = NUC_A;
				end
			endcase
		end
		return r;
	endfunction

	// residue letters: A-Z in either case, without B J O U X Z; coded symbols: below the limit
	function automatic logic residue_valid(input logic [SYM_W-1:0] sym, input logic coded,
			input logic [LIMIT_W-1:0] limit);
		logic [SYM_W-1:0] up;
		logic             letter;
		up     = sym & 8'hDF;
		letter = (up >= "A") && (up <= "Z") && (sym[7] == 1'b0);
		if (coded)
			return sym < {1'b0, limit};
		return letter && (up != "B") && (up != "J") && (up != "O") && (up != "U")
			&& (up != "X") && (up != "Z");
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
			input logic [WEIGHT_W-1:0] w, input logic en);
		logic [SUM_W:0] s;
		s = {1'b0, sum} + {{(SUM_W+1-WEIGHT_W){1'b0}}, w};
		if (!en)
			return sum;
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

// ----- rtl/core/pairwise_site_distance_counter_top.sv -----
// Pairwise site distance counter: configuration registers, front end, queue, back end.
// Uses psdc_pkg, psdc_front, psdc_queue, psdc_back.
// Sites: one transfer per cycle; stall only while both queue entries hold pairs.
// Result: the pair summary passes through the queue and, unless there are no valid sites or
// the ratio is one, the bit-serial restoring divider; one pair at a time, two more can wait.
// Reset (arst_n low): sums cleared, queue emptied, back end to idle; registers to 0, 0, 20.
module pairwise_site_distance_counter_top #(
	parameter int MAX_SITES  = 1048576,
	parameter int RATIO_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psdc_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [psdc_pkg::LIMIT_W-1:0]  cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// symbol_first[7:0], symbol_second[15:8], site_weight[31:16]
	input  logic [31:0]                   s_tdata,
	input  logic                          s_tlast,      // last_site
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mismatch_weight, transition_weight, transversion_weight, valid_weight,
	// distance_ratio, no_valid_sites, at_or_over_limit, zero fill
	output logic [((4 * psdc_pkg::SUM_W + RATIO_BITS + 10) / 8) * 8 - 1:0] m_tdata
);

	localparam int SW      = psdc_pkg::SUM_W;
	localparam int TALLY_W = $clog2(MAX_SITES + 1);
	localparam int FIELD_W = 4 * SW + RATIO_BITS + 3;
	localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;
	localparam logic [RATIO_BITS:0] RATIO_ONE  = (RATIO_BITS+1)'(1) << RATIO_BITS;
	localparam logic [RATIO_BITS:0] RATIO_HIGH = (RATIO_BITS+1)'(3) << (RATIO_BITS - 2);

	psdc_pkg::cfg_t       cfg_q;
	psdc_pkg::pair_sums_t push_data, pop_data;
	logic                 push, pop, q_full, q_empty;
	logic [SW-1:0]        mismatch, transition, transversion, valid;
	logic [RATIO_BITS:0]  ratio;
	logic                 none, high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind  <= psdc_pkg::KIND_NUC;
			cfg_q.coded <= 1'b0;
			cfg_q.limit <= psdc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				psdc_pkg::CFG_KIND:  cfg_q.kind  <= cfg_data[1:0];
				psdc_pkg::CFG_CODED: cfg_q.coded <= cfg_data[0];
				psdc_pkg::CFG_LIMIT: cfg_q.limit <= cfg_data;
				default:             cfg_q       <= cfg_q;
			endcase
		end
	end

	psdc_front #(
		.MAX_SITES (MAX_SITES),
		.TALLY_W   (TALLY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	psdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	psdc_back #(
		.RATIO_BITS (RATIO_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.mismatch     (mismatch),
		.transition   (transition),
		.transversion (transversion),
		.valid        (valid),
		.ratio        (ratio),
		.none         (none),
		.high         (high)
	);

	assign m_tdata = OUT_W'({high, none, ratio, valid, transversion, transition, mismatch});

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && none |-> (ratio == '0) && !high)
		else $error("no_valid_sites with nonzero ratio or limit flag");

	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ratio <= RATIO_ONE))
		else $error("distance ratio above one");

	a_high_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !none |-> (high == (ratio >= RATIO_HIGH)))
		else $error("limit flag disagrees with ratio");

endmodule

// ----- rtl/core/psdc_front.sv -----
// Front end: accepts sites, classifies the symbol pair and accumulates the
// weighted sums; pushes a pair summary into the queue on the last site. Uses psdc_pkg.
module psdc_front #(
	parameter int MAX_SITES = 1048576,
	parameter int TALLY_W   = 21
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psdc_pkg::cfg_t        cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic                  s_tlast,
	input  logic                  q_full,
	output logic                  push,
	output psdc_pkg::pair_sums_t  push_data
);

	logic [psdc_pkg::SUM_W-1:0] mismatch_q, transition_q, transversion_q, valid_q;
	logic [psdc_pkg::SUM_W-1:0] mismatch_nx, transition_nx, transversion_nx, valid_nx;
	logic [TALLY_W-1:0]          tally_q, tally_nx;
	logic [psdc_pkg::SYM_W-1:0]  sym_a, sym_b;
	logic [psdc_pkg::WEIGHT_W-1:0] wt;
	psdc_pkg::nuc_t              na, nb;
	logic                        site_ok, diff, ts, is_nuc, accept;

	assign sym_a    = s_tdata[7:0];
	assign sym_b    = s_tdata[15:8];
	assign wt       = s_tdata[31:16];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_nuc   = (cfg.kind == psdc_pkg::KIND_NUC);

	always_comb begin
		na      = psdc_pkg::nuc_decode(sym_a, cfg.coded);
		nb      = psdc_pkg::nuc_decode(sym_b, cfg.coded);
		site_ok = 1'b1;
		diff    = (sym_a != sym_b);
		ts      = 1'b0;
		case (cfg.kind)
			psdc_pkg::KIND_NUC: begin
				site_ok = na.ok && nb.ok;
				diff    = (na.code != nb.code);
				ts      = ((na.code ^ nb.code) == psdc_pkg::TRANSITION_XOR);
			end
			psdc_pkg::KIND_AMINO: begin
				site_ok = psdc_pkg::residue_valid(sym_a, cfg.coded, cfg.limit)
					&& psdc_pkg::residue_valid(sym_b, cfg.coded, cfg.limit);
			end
			default: begin
				site_ok = 1'b1;
			end
		endcase
	end

	always_comb begin
		valid_nx        = psdc_pkg::sat_add(valid_q, wt, site_ok);
		mismatch_nx     = psdc_pkg::sat_add(mismatch_q, wt, site_ok && diff);
		transition_nx   = psdc_pkg::sat_add(transition_q, wt, site_ok && diff && is_nuc && ts);
		transversion_nx = psdc_pkg::sat_add(transversion_q, wt,
			site_ok && diff && is_nuc && !ts);
		tally_nx        = (tally_q == TALLY_W'(MAX_SITES)) ? tally_q : tally_q + 1'b1;
	end

	assign push                   = accept && s_tlast;
	assign push_data.mismatch     = mismatch_nx;
	assign push_data.transition   = transition_nx;
	assign push_data.transversion = transversion_nx;
	assign push_data.valid        = valid_nx;
	assign push_data.den          = (cfg.kind[1]) ?
		{{(psdc_pkg::SUM_W-TALLY_W){1'b0}}, tally_nx} : valid_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q     <= '0;
			transition_q   <= '0;
			transversion_q <= '0;
			valid_q        <= '0;
			tally_q        <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				mismatch_q     <= '0;
				transition_q   <= '0;
				transversion_q <= '0;
				valid_q        <= '0;
				tally_q        <= '0;
			end else begin
				mismatch_q     <= mismatch_nx;
				transition_q   <= transition_nx;
				transversion_q <= transversion_nx;
				valid_q        <= valid_nx;
				tally_q        <= tally_nx;
			end
		end
	end

endmodule

// ----- rtl/core/psdc_queue.sv -----
// Two-entry queue of pair summaries between front and back end.
// Uses psdc_pkg.
module psdc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  psdc_pkg::pair_sums_t push_data,
	input  logic                 pop,
	output psdc_pkg::pair_sums_t pop_data,
	output logic                 full,
	output logic                 empty
);

	psdc_pkg::pair_sums_t entry_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/psdc_back.sv -----
// Back end: takes a pair summary, runs the restoring ratio divider one bit
// per cycle if mismatch < den; holds the result for output. Uses psdc_pkg.
module psdc_back #(
	parameter int RATIO_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  psdc_pkg::pair_sums_t       q_data,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [psdc_pkg::SUM_W-1:0] mismatch,
	output logic [psdc_pkg::SUM_W-1:0] transition,
	output logic [psdc_pkg::SUM_W-1:0] transversion,
	output logic [psdc_pkg::SUM_W-1:0] valid,
	output logic [RATIO_BITS:0]        ratio,
	output logic                       none,
	output logic                       high
);

	localparam int CNT_W = $clog2(RATIO_BITS);
	localparam int SW    = psdc_pkg::SUM_W;

	psdc_pkg::bk_state_t state_q, state_nx;
	logic [SW-1:0]       mis_q, ts_q, tv_q, val_q, den_q, rem_q;
	logic [RATIO_BITS:0] ratio_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                none_q, high_q;
	logic                ld_none, ld_ge, ld_high, step_done, sub_ok;
	logic [SW:0]         rem_sh;
	logic [SW+1:0]       mis4, den3;

	assign ld_none   = (q_data.den == '0);
	assign ld_ge     = (q_data.mismatch >= q_data.den);
	assign mis4      = {q_data.mismatch, 2'b00};
	assign den3      = {2'b00, q_data.den} + {1'b0, q_data.den, 1'b0};
	assign ld_high   = !ld_none && (mis4 >= den3);
	assign rem_sh    = {rem_q, 1'b0};
	assign sub_ok    = (rem_sh >= {1'b0, den_q});
	assign step_done = (cnt_q == CNT_W'(RATIO_BITS - 1));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			psdc_pkg::BK_IDLE: begin
				if (!q_empty)
					state_nx = (ld_none || ld_ge) ? psdc_pkg::BK_HOLD : psdc_pkg::BK_DIV;
			end
			psdc_pkg::BK_DIV: begin
				if (step_done)
					state_nx = psdc_pkg::BK_HOLD;
			end
			psdc_pkg::BK_HOLD: begin
				if (m_tready)
					state_nx = psdc_pkg::BK_IDLE;
			end
			default: state_nx = psdc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			psdc_pkg::BK_IDLE: pop      = !q_empty;
			psdc_pkg::BK_HOLD: m_tvalid = 1'b1;
			default: begin
				pop      = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= psdc_pkg::BK_IDLE;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mis_q   <= q_data.mismatch;
			ts_q    <= q_data.transition;
			tv_q    <= q_data.transversion;
			val_q   <= q_data.valid;
			den_q   <= q_data.den;
			rem_q   <= q_data.mismatch;
			none_q  <= ld_none;
			high_q  <= ld_high;
			cnt_q   <= '0;
			ratio_q <= (!ld_none && ld_ge) ? {1'b1, {RATIO_BITS{1'b0}}} : '0;
		end else if (state_q == psdc_pkg::BK_DIV) begin
			cnt_q   <= cnt_q + 1'b1;
			rem_q   <= sub_ok ? SW'(rem_sh - {1'b0, den_q}) : rem_sh[SW-1:0];
			ratio_q <= {ratio_q[RATIO_BITS-1:0], sub_ok};
		end
	end

	assign mismatch     = mis_q;
	assign transition   = ts_q;
	assign transversion = tv_q;
	assign valid        = val_q;
	assign ratio        = ratio_q;
	assign none         = none_q;
	assign high         = high_q;

endmodule
